// ===== src/psqm_pkg.sv =====
// psqm_pkg: shared types, command and status codes for the process state queue manager.
// Used by psqm_ram and process_state_queue_manager; depends on nothing.
`default_nettype none
package psqm_pkg;

  localparam int MaxProcsDefault = 16;

  // command codes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_KILL   = 3'd2;
  localparam logic [2:0] OP_BLOCK  = 3'd3;
  localparam logic [2:0] OP_WAKEUP = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // queue selects (upper address bits of the shared store)
  localparam logic [1:0] Q_READY   = 2'd0;
  localparam logic [1:0] Q_RUNNING = 2'd1;
  localparam logic [1:0] Q_BLOCKED = 2'd2;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] time_need;
    logic [15:0] pid;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_APPEND,
    S_DISP_RD,
    S_DISP_WR,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== src/psqm_ram.sv =====
// psqm_ram: single write port, single registered read port entry store.
// Depends on psqm_pkg for the entry width default.
`default_nettype none
module psqm_ram #(
  parameter int AW = 6,
  parameter int DW = psqm_pkg::EntryW
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/process_state_queue_manager.sv =====
// process_state_queue_manager: ready/running/blocked process queues in one shared store.
// Depends on psqm_pkg and psqm_ram.
//
// Channel | Dir | Fields in tdata (lowest bit first)
// in_     | in  | op[2:0] pid[18:3] time_need[34:19] prio[42:35], zero pad to 48
// out_    | out | status[1:0] dispatched[2] dispatched_pid[18:3] dispatched_prio[26:19]
//         |     | ready_count[31:27] running_count[36:32] blocked_count[41:37], pad to 48
//
// One command at a time. Create/none: exec, then a dispatch read, a dispatch write
// (skipped when ready is empty) and the out state. Kill, block and wakeup walk the
// searched queue through the store's read port, one entry a cycle, append the hit for
// block and wakeup, then dispatch as above. The result register holds until out_tready;
// in_tready stays low from acceptance until the cycle after the result transaction.
// Synchronous active-low reset empties all queues; the store itself needs no clearing
// since only entries below a queue's length are read.
`default_nettype none
module process_state_queue_manager #(
  parameter int MAX_PROCS = psqm_pkg::MaxProcsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // op, pid, time_need, prio
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata   // status, dispatched, pid, prio, three counts
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int AW = IW + 2;

  psqm_pkg::state_t state_r, state_nxt;

  // command
  logic [2:0]  op_r;
  logic [15:0] pid_r;
  logic [15:0] tneed_r;
  logic [7:0]  prio_r;

  // queue bookkeeping
  logic [IW-1:0] head_r;
  logic [CW-1:0] rlen_r, runlen_r, blen_r;

  // walk
  logic [1:0]    src_r;
  logic [CW-1:0] n_r, rd_r, wr_r;
  logic          rdv_r, hit_r;
  psqm_pkg::entry_t last_r;

  // result
  logic [1:0]  status_r;
  logic        disp_r;
  logic [15:0] dpid_r;
  logic [7:0]  dprio_r;

  // store ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  psqm_pkg::entry_t wdata, rdata;

  psqm_ram #(.AW(AW), .DW(psqm_pkg::EntryW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // derived values
  logic [IW:0]   tail_sum, head_sum;
  logic [IW-1:0] tail_idx, head_inc;
  logic [CW+1:0] total;
  logic          full, walk_done, match;

  always_comb begin
    tail_sum = (IW+1)'(head_r) + (IW+1)'(rlen_r);
    tail_idx = (tail_sum >= (IW+1)'(MAX_PROCS)) ?
               IW'(tail_sum - (IW+1)'(MAX_PROCS)) : tail_sum[IW-1:0];
    head_sum = (IW+1)'(head_r) + (IW+1)'(1);
    head_inc = (head_sum >= (IW+1)'(MAX_PROCS)) ? '0 : head_sum[IW-1:0];
    total    = (CW+2)'(rlen_r) + (CW+2)'(runlen_r) + (CW+2)'(blen_r);
    full     = total >= (CW+2)'(MAX_PROCS);
    walk_done = !rdv_r && (rd_r >= n_r);
    match    = rdata.pid == pid_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psqm_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = psqm_pkg::S_EXEC;
      end
      psqm_pkg::S_EXEC: begin
        if (op_r == psqm_pkg::OP_KILL || op_r == psqm_pkg::OP_BLOCK ||
            op_r == psqm_pkg::OP_WAKEUP) begin
          state_nxt = psqm_pkg::S_WALK;
        end else begin
          state_nxt = psqm_pkg::S_DISP_RD;
        end
      end
      psqm_pkg::S_WALK: begin
        if (walk_done) begin
          state_nxt = (hit_r && op_r != psqm_pkg::OP_KILL) ?
                      psqm_pkg::S_APPEND : psqm_pkg::S_DISP_RD;
        end
      end
      psqm_pkg::S_APPEND: state_nxt = psqm_pkg::S_DISP_RD;
      psqm_pkg::S_DISP_RD: begin
        state_nxt = (rlen_r != '0) ? psqm_pkg::S_DISP_WR : psqm_pkg::S_OUT;
      end
      psqm_pkg::S_DISP_WR: state_nxt = psqm_pkg::S_OUT;
      psqm_pkg::S_OUT: begin
        if (out_tready) state_nxt = psqm_pkg::S_IDLE;
      end
      default: state_nxt = psqm_pkg::S_IDLE;
    endcase
  end

  // handshakes and store port control
  always_comb begin
    in_tready  = state_r == psqm_pkg::S_IDLE;
    out_tvalid = state_r == psqm_pkg::S_OUT;
    we    = 1'b0;
    waddr = '0;
    wdata = last_r;
    raddr = {src_r, rd_r[IW-1:0]};
    unique case (state_r)
      psqm_pkg::S_EXEC: begin
        if (op_r == psqm_pkg::OP_CREATE && !full) begin
          we    = 1'b1;
          waddr = {psqm_pkg::Q_READY, tail_idx};
          wdata = '{prio: prio_r, time_need: tneed_r, pid: pid_r};
        end
      end
      psqm_pkg::S_WALK: begin
        // compaction: keep non-matching entries
        if (rdv_r && !match) begin
          we    = 1'b1;
          waddr = {src_r, wr_r[IW-1:0]};
          wdata = rdata;
        end
      end
      psqm_pkg::S_APPEND: begin
        we = 1'b1;
        if (op_r == psqm_pkg::OP_BLOCK) begin
          waddr = {psqm_pkg::Q_BLOCKED, blen_r[IW-1:0]};
        end else begin
          waddr = {psqm_pkg::Q_READY, tail_idx};
        end
      end
      psqm_pkg::S_DISP_RD: raddr = {psqm_pkg::Q_READY, head_r};
      psqm_pkg::S_DISP_WR: begin
        we    = 1'b1;
        waddr = {psqm_pkg::Q_RUNNING, runlen_r[IW-1:0]};
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= psqm_pkg::S_IDLE;
      head_r   <= '0;
      rlen_r   <= '0;
      runlen_r <= '0;
      blen_r   <= '0;
      rdv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        psqm_pkg::S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tdata[2:0];
            pid_r   <= in_tdata[18:3];
            tneed_r <= in_tdata[34:19];
            prio_r  <= in_tdata[42:35];
          end
        end
        psqm_pkg::S_EXEC: begin
          status_r <= psqm_pkg::STAT_DONE;
          disp_r   <= 1'b0;
          dpid_r   <= '0;
          dprio_r  <= '0;
          rd_r     <= '0;
          wr_r     <= '0;
          rdv_r    <= 1'b0;
          hit_r    <= 1'b0;
          if (op_r == psqm_pkg::OP_WAKEUP) begin
            src_r <= psqm_pkg::Q_BLOCKED;
            n_r   <= blen_r;
          end else begin
            src_r <= psqm_pkg::Q_RUNNING;
            n_r   <= runlen_r;
          end
          if (op_r == psqm_pkg::OP_CREATE) begin
            if (full) status_r <= psqm_pkg::STAT_FULL;
            else rlen_r <= rlen_r + CW'(1);
          end
        end
        psqm_pkg::S_WALK: begin
          if (rdv_r) begin
            if (match) begin
              hit_r  <= 1'b1;
              last_r <= rdata;
            end else begin
              wr_r <= wr_r + CW'(1);
            end
          end
          rdv_r <= rd_r < n_r;
          if (rd_r < n_r) rd_r <= rd_r + CW'(1);
          if (walk_done) begin
            if (src_r == psqm_pkg::Q_BLOCKED) blen_r <= wr_r;
            else runlen_r <= wr_r;
            if (!hit_r) status_r <= psqm_pkg::STAT_NOT_FOUND;
          end
        end
        psqm_pkg::S_APPEND: begin
          if (op_r == psqm_pkg::OP_BLOCK) blen_r <= blen_r + CW'(1);
          else rlen_r <= rlen_r + CW'(1);
        end
        psqm_pkg::S_DISP_WR: begin
          runlen_r <= runlen_r + CW'(1);
          rlen_r   <= rlen_r - CW'(1);
          head_r   <= head_inc;
          disp_r   <= 1'b1;
          dpid_r   <= rdata.pid;
          dprio_r  <= rdata.prio;
        end
        default: ;
      endcase
    end
  end

  // result packing, counts masked to five bits
  logic [31:0] rc32, runc32, bc32;
  always_comb begin
    rc32   = 32'(rlen_r);
    runc32 = 32'(runlen_r);
    bc32   = 32'(blen_r);
    out_tdata = {6'd0, bc32[4:0], runc32[4:0], rc32[4:0],
                 dprio_r, dpid_r, disp_r, status_r};
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for process_state_queue_manager.
// Drives commands on the in_ stream, predicts each result with a queue model,
// and checks the out_ stream; depends on psqm_pkg and the RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = psqm_pkg::MaxProcsDefault;
  localparam int CycleLimit = 400000;
  localparam int RandItems = 1250;

  // first member in the highest bits: status lands at out_tdata[1:0]
  typedef struct packed {
    logic [4:0]  n_blocked;
    logic [4:0]  n_running;
    logic [4:0]  n_ready;
    logic [7:0]  dprio;
    logic [15:0] dpid;
    logic        dispatched;
    logic [1:0]  status;
  } sched_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] pid;
    logic [15:0] tneed;
    logic [7:0]  prio;
    bit          fixed;   // result typed in below
    logic [1:0]  status;
    logic [4:0]  n_ready;
    logic [4:0]  n_running;
    logic [4:0]  n_blocked;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;

  process_state_queue_manager dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model of the three process queues
  psqm_pkg::entry_t ready_q[$];
  psqm_pkg::entry_t running_q[$];
  psqm_pkg::entry_t blocked_q[$];
  sched_result_t pending_results[$];

  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;
  int hold_cycles = 0;

  // remove all entries with matching id; keep the last one in hit
  function automatic bit purge_pid(ref psqm_pkg::entry_t q[$], input logic [15:0] id,
                                   output psqm_pkg::entry_t hit);
    psqm_pkg::entry_t kept[$];
    bit found;
    found = 1'b0;
    hit = '0;
    foreach (q[i]) begin
      if (q[i].pid == id) begin
        found = 1'b1;
        hit = q[i];
      end else begin
        kept.push_back(q[i]);
      end
    end
    q = kept;
    return found;
  endfunction

  function automatic sched_result_t schedule_step(logic [2:0] op, logic [15:0] pid,
                                                  logic [15:0] tneed, logic [7:0] prio);
    sched_result_t r;
    psqm_pkg::entry_t e;
    r = '0;
    r.status = psqm_pkg::STAT_DONE;
    case (op)
      psqm_pkg::OP_CREATE: begin
        if (ready_q.size() + running_q.size() + blocked_q.size() >= Depth) begin
          r.status = psqm_pkg::STAT_FULL;
        end else begin
          e.pid = pid;
          e.time_need = tneed;
          e.prio = prio;
          ready_q.push_back(e);
        end
      end
      psqm_pkg::OP_KILL: begin
        if (!purge_pid(running_q, pid, e)) r.status = psqm_pkg::STAT_NOT_FOUND;
      end
      psqm_pkg::OP_BLOCK: begin
        if (purge_pid(running_q, pid, e)) blocked_q.push_back(e);
        else r.status = psqm_pkg::STAT_NOT_FOUND;
      end
      psqm_pkg::OP_WAKEUP: begin
        if (purge_pid(blocked_q, pid, e)) ready_q.push_back(e);
        else r.status = psqm_pkg::STAT_NOT_FOUND;
      end
      default: ;
    endcase
    // dispatch the head of ready
    if (ready_q.size() > 0) begin
      e = ready_q.pop_front();
      running_q.push_back(e);
      r.dispatched = 1'b1;
      r.dpid = e.pid;
      r.dprio = e.prio;
    end
    r.n_ready = 5'(ready_q.size());
    r.n_running = 5'(running_q.size());
    r.n_blocked = 5'(blocked_q.size());
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold
  initial begin : rx_proc
    int w;
    @(posedge clk iff rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) w = 0;
      if (w > 0 || hold_rx) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles == 1) hold_rx <= 1'b0;
    end
  end

  // check each accepted result
  always @(posedge clk) begin
    sched_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sched_result_t'(out_tdata[41:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || out_tdata[47:42] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: st %0d/%0d disp %0d/%0d pid %h/%h pr %h/%h",
                      " cnt %0d,%0d,%0d / %0d,%0d,%0d"},
                     want.status, got.status, want.dispatched, got.dispatched,
                     want.dpid, got.dpid, want.dprio, got.dprio,
                     want.n_ready, want.n_running, want.n_blocked,
                     got.n_ready, got.n_running, got.n_blocked);
        end
      end
    end
  end

  // send one transaction and queue its prediction; in_tvalid stays high when
  // the next transaction follows without a gap
  task automatic send_cmd(logic [2:0] op, logic [15:0] pid, logic [15:0] tneed,
                          logic [7:0] prio, bit gap);
    int w;
    sched_result_t r;
    w = gap ? $urandom_range(0, 9) : 0;
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tdata <= {5'b0, prio, tneed, pid, op};
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
    r = schedule_step(op, pid, tneed, prio);
    pending_results.push_back(r);
  endtask

  cmd_row_t dir_rows[$];

  function automatic cmd_row_t mk(logic [2:0] op, logic [15:0] pid, logic [15:0] tn,
                                  logic [7:0] pr, bit fixed = 0, logic [1:0] st = 0,
                                  logic [4:0] nr = 0, logic [4:0] nu = 0,
                                  logic [4:0] nb = 0);
    cmd_row_t c;
    c.op = op; c.pid = pid; c.tneed = tn; c.prio = pr; c.fixed = fixed;
    c.status = st; c.n_ready = nr; c.n_running = nu; c.n_blocked = nb;
    return c;
  endfunction

  // pick an id that tends to match something live
  function automatic logic [15:0] pick_pid(logic [15:0] pool[$]);
    if (pool.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom());
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  initial begin : stim_proc
    logic [15:0] pool[$];
    logic [2:0] op;
    logic [15:0] id;
    sched_result_t want;
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    dir_rows.push_back(mk(psqm_pkg::OP_NONE, 16'h0000, 16'h0000, 8'h00, 1,
                          psqm_pkg::STAT_DONE, 0, 0, 0));
    dir_rows.push_back(mk(psqm_pkg::OP_KILL, 16'h1234, 16'h0000, 8'h00, 1,
                          psqm_pkg::STAT_NOT_FOUND, 0, 0, 0));
    dir_rows.push_back(mk(psqm_pkg::OP_BLOCK, 16'hFFFF, 16'h0000, 8'h00, 1,
                          psqm_pkg::STAT_NOT_FOUND, 0, 0, 0));
    dir_rows.push_back(mk(psqm_pkg::OP_WAKEUP, 16'h0000, 16'h0000, 8'h00, 1,
                          psqm_pkg::STAT_NOT_FOUND, 0, 0, 0));
    dir_rows.push_back(mk(psqm_pkg::OP_CREATE, 16'hFFFF, 16'hFFFF, 8'hFF, 1,
                          psqm_pkg::STAT_DONE, 0, 1, 0));
    dir_rows.push_back(mk(psqm_pkg::OP_CREATE, 16'h0000, 16'h0000, 8'h00, 1,
                          psqm_pkg::STAT_DONE, 0, 2, 0));
    dir_rows.push_back(mk(psqm_pkg::OP_CREATE, 16'hFFFF, 16'h5555, 8'hAA));
    dir_rows.push_back(mk(psqm_pkg::OP_BLOCK, 16'hFFFF, 16'h0, 8'h0)); // two matches, last kept
    dir_rows.push_back(mk(psqm_pkg::OP_WAKEUP, 16'hFFFF, 16'h0, 8'h0));
    dir_rows.push_back(mk(psqm_pkg::OP_KILL, 16'h0000, 16'h0, 8'h0));
    dir_rows.push_back(mk(3'd5, 16'hAAAA, 16'hAAAA, 8'h55));      // unknown ops act as none
    dir_rows.push_back(mk(3'd6, 16'h5555, 16'h5555, 8'hAA));
    dir_rows.push_back(mk(3'd7, 16'h0, 16'h0, 8'h0));
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].op, dir_rows[i].pid, dir_rows[i].tneed, dir_rows[i].prio, 1);
      if (dir_rows[i].fixed) begin
        want = pending_results[$];
        if (want.status != dir_rows[i].status || want.n_ready != dir_rows[i].n_ready ||
            want.n_running != dir_rows[i].n_running ||
            want.n_blocked != dir_rows[i].n_blocked) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
        end
      end
    end
    // fill to full; the creates past full, and one more after the loop, are refused
    for (k = 0; k < Depth; k++) send_cmd(psqm_pkg::OP_CREATE, 16'(k + 100), 16'(k), 8'(k), 0);
    send_cmd(psqm_pkg::OP_CREATE, 16'hBEEF, 16'h0, 8'h0, 1);

    // sender pauses until every result has arrived
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);

    // random part; long receiver hold in the middle
    for (k = 0; k < RandItems; k++) begin
      if (k == RandItems / 2) begin
        hold_cycles <= 300;
        hold_rx <= 1'b1;
      end
      pool.delete();
      foreach (running_q[i]) pool.push_back(running_q[i].pid);
      foreach (blocked_q[i]) pool.push_back(blocked_q[i].pid);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = psqm_pkg::OP_CREATE;
        6, 7, 8: op = psqm_pkg::OP_KILL;
        9, 10, 11, 12: op = psqm_pkg::OP_BLOCK;
        13, 14, 15, 16: op = psqm_pkg::OP_WAKEUP;
        17: op = psqm_pkg::OP_NONE;
        default: op = 3'($urandom_range(5, 7));
      endcase
      // small id space so duplicate ids appear
      if (op == psqm_pkg::OP_CREATE)
        id = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
      else if (op == psqm_pkg::OP_WAKEUP && blocked_q.size() > 0 &&
               $urandom_range(0, 3) != 0)
        id = blocked_q[$urandom_range(0, blocked_q.size() - 1)].pid;
      else
        id = pick_pid(pool);
      send_cmd(op, id, 16'($urandom()), 8'($urandom()), $urandom_range(0, 3) != 0);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
